// File: hw/rtl/paf_pkg.sv
// shared types, constants and helpers of the pair adhesion force pipeline
package paf_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_GAIN = 1'b0;
  localparam logic [0:0] REG_LAW  = 1'b1;

  // force law codes
  localparam logic LAW_LINEAR = 1'b0;
  localparam logic LAW_SQUARE = 1'b1;

  // root unit: one result bit per stage
  localparam int SQRT_STAGES = 32;

  // divider: 65-bit dividend, 32-bit divisor, 33 quotient bits, one per stage
  localparam int DIV_D_W = 32;
  localparam int DIV_Q_W = 33;
  localparam int DIV_N_W = DIV_D_W + DIV_Q_W;

  // register stages from input to output register
  localparam int PIPE_DEPTH = 3 + SQRT_STAGES + 1 + DIV_Q_W + 6 + DIV_Q_W + 3;

  // cap on the force coefficient magnitude
  localparam logic [32:0] CM_CAP = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic [30:0]        inner_radius_sum;
    logic [30:0]        outer_radius_sum;
    logic [30:0]        own_mass_a;
    logic [30:0]        shell_mass_a;
    logic               adhesive_a;
    logic [30:0]        own_mass_b;
    logic [30:0]        shell_mass_b;
    logic               adhesive_b;
  } pair_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] vir_xx;
    logic signed [31:0] vir_yy;
    logic signed [31:0] vir_zz;
    logic signed [31:0] vir_xy;
    logic signed [31:0] vir_xz;
    logic signed [31:0] vir_yz;
    logic               in_band;
  } pair_out_t;

  // sideband carried alongside the root unit
  typedef struct packed {
    logic [2:0][31:0] sm;
    logic [2:0]       sn;
    logic [30:0]      inner;
    logic [30:0]      outer;
    logic [63:0]      m;
  } sq_side_t;

  // sideband carried alongside the ratio divider
  typedef struct packed {
    logic [2:0][31:0] sm;
    logic [2:0]       sn;
    logic [30:0]      inner;
    logic [31:0]      r;
    logic [63:0]      m;
    logic [31:0]      dm;
    logic             cneg_lin;
    logic             band;
  } dv_side_t;

  // sideband carried alongside the force dividers
  typedef struct packed {
    logic [2:0][31:0] sm;
    logic [2:0]       sn;
    logic [31:0]      r;
    logic [32:0]      cm;
    logic             cneg;
    logic             band;
  } fc_side_t;

  // magnitude of a two's complement word
  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // saturated magnitude for a signed 32-bit result
  function automatic logic [31:0] sat_mag(logic [47:0] m, logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (m > 48'h8000_0000) ? 32'h8000_0000 : m[31:0];
    end else begin
      res = (m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return res;
  endfunction

  // saturated signed encoding of a magnitude and sign
  function automatic logic [31:0] enc_sat(logic [47:0] m, logic neg);
    logic [31:0] mg;
    mg = sat_mag(m, neg);
    return neg ? (~mg + 32'd1) : mg;
  endfunction

endpackage

// File: hw/rtl/paf_sqrt.sv
// pipelined integer square root, one root bit per stage
module paf_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  localparam int NS = paf_pkg::SQRT_STAGES;

  logic [63:0] v_q   [NS-1];
  logic [63:0] res_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] v_in;
    logic [63:0] res_in;
    logic [64:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign v_in   = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign res_in = res_q[i-1];
    end

    // trial subtract of res + bit
    assign trial = {1'b0, res_in} + {1'b0, BIT};
    assign take  = {1'b0, v_in} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[i] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
      end
    end

    if (i < NS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[i] <= take ? (v_in - trial[63:0]) : v_in;
        end
      end
    end
  end

  assign root_o = res_q[NS-1][31:0];

endmodule

// File: hw/rtl/paf_div.sv
// pipelined restoring divider, one quotient bit per stage
module paf_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [paf_pkg::DIV_N_W-1:0] num_i,
  input  logic [paf_pkg::DIV_D_W-1:0] den_i,
  output logic [paf_pkg::DIV_Q_W-1:0] quo_o
);

  localparam int QW = paf_pkg::DIV_Q_W;
  localparam int DW = paf_pkg::DIV_D_W;
  localparam int NW = paf_pkg::DIV_N_W;

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] lo_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lo_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = num_i[NW-1 -: DW];
      assign lo_in  = num_i[QW-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign den_in = den_q[i-1];
    end

    // shift in the next dividend bit and try the divisor
    assign trial = {rem_in, lo_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[i] <= {lo_in[QW-2:0], take};
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= take ? diff[DW-1:0] : trial[DW-1:0];
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo_o = lo_q[QW-1];

endmodule

// File: hw/rtl/pair_adhesion_force.sv
// pair adhesion force pipeline: top level
//
// One neighbour pair enters on the in channel (valid/ready) and one result
// leaves on the out channel (valid/ready): the force on the first particle,
// the six virial products and the in_band flag. The caller negates the force
// for the second particle and does all accumulation. The user must write the
// configuration (gain, law_mode) through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the pipeline is empty, which the block does not enforce; a write
// takes effect at once. From input transfer to result valid there are three
// input stages, a 32-stage square root, a band test stage, a 33-stage ratio
// divider, six stages of coefficient arithmetic, 33-stage force dividers and
// three output stages. Throughput is one pair per cycle unless the output
// stalls. The whole pipeline advances together; when the output register
// holds a result that is not taken, every stage holds and in_ready_o is
// low, so nothing is dropped or repeated. Reset clears the valid bits and the
// configuration (gain 0, linear law); the block is ready as soon as reset ends.
module pair_adhesion_force (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  paf_pkg::pair_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output paf_pkg::pair_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int NS = paf_pkg::SQRT_STAGES;
  localparam int QW = paf_pkg::DIV_Q_W;
  localparam int PD = paf_pkg::PIPE_DEPTH;

  logic          adv;
  logic [PD-1:0] vld_q;
  logic [31:0]   gain_q;
  logic          law_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      law_q  <= paf_pkg::LAW_LINEAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        paf_pkg::REG_GAIN: gain_q <= cfg_data_i;
        paf_pkg::REG_LAW:  law_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // global advance and valid line
  assign adv        = !vld_q[PD-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PD-2:0], in_valid_i};
    end
  end

  // stage 1: magnitudes, signs and adhesive mass sum
  logic [2:0][31:0] s1_sm_q;
  logic [2:0]       s1_sn_q;
  logic [30:0]      s1_inner_q;
  logic [30:0]      s1_outer_q;
  logic [31:0]      s1_msum_q;
  logic [30:0]      ma;
  logic [30:0]      mb;

  assign ma = in_data_i.adhesive_a ? in_data_i.own_mass_a : in_data_i.shell_mass_a;
  assign mb = in_data_i.adhesive_b ? in_data_i.own_mass_b : in_data_i.shell_mass_b;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sm_q[0] <= paf_pkg::mag32(in_data_i.sep_x);
      s1_sm_q[1] <= paf_pkg::mag32(in_data_i.sep_y);
      s1_sm_q[2] <= paf_pkg::mag32(in_data_i.sep_z);
      s1_sn_q    <= {in_data_i.sep_z[31], in_data_i.sep_y[31], in_data_i.sep_x[31]};
      s1_inner_q <= in_data_i.inner_radius_sum;
      s1_outer_q <= in_data_i.outer_radius_sum;
      s1_msum_q  <= {1'b0, ma} + {1'b0, mb};
    end
  end

  // stage 2: squares and mass times gain
  logic [2:0][63:0]  s2_sq_q;
  paf_pkg::sq_side_t s2_side_q;
  paf_pkg::sq_side_t s3_side_q;
  logic [63:0]       s3_rsq_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_sq_q[k] <= {32'd0, s1_sm_q[k]} * {32'd0, s1_sm_q[k]};
      end
      s2_side_q.sm    <= s1_sm_q;
      s2_side_q.sn    <= s1_sn_q;
      s2_side_q.inner <= s1_inner_q;
      s2_side_q.outer <= s1_outer_q;
      s2_side_q.m     <= {32'd0, s1_msum_q} * {32'd0, gain_q};
    end
  end

  // stage 3: squared distance
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_rsq_q  <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_side_q <= s2_side_q;
    end
  end

  // distance root with its sideband line
  logic [31:0]       root;
  paf_pkg::sq_side_t sq_line_q [NS];

  paf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (s3_rsq_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_line_q[0] <= s3_side_q;
      for (int i = 1; i < NS; i++) begin
        sq_line_q[i] <= sq_line_q[i-1];
      end
    end
  end

  // band test and linear displacement
  paf_pkg::sq_side_t sq_out;
  paf_pkg::dv_side_t b1_side_q;
  logic [31:0]       midr;

  assign sq_out = sq_line_q[NS-1];
  assign midr   = 32'(({1'b0, sq_out.inner} + {1'b0, sq_out.outer}) >> 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_side_q.sm       <= sq_out.sm;
      b1_side_q.sn       <= sq_out.sn;
      b1_side_q.inner    <= sq_out.inner;
      b1_side_q.r        <= root;
      b1_side_q.m        <= sq_out.m;
      b1_side_q.dm       <= (root >= midr) ? (root - midr) : (midr - root);
      b1_side_q.cneg_lin <= root > midr;
      b1_side_q.band     <= (root > {1'b0, sq_out.inner}) && (root < {1'b0, sq_out.outer});
    end
  end

  // inner over distance ratio for the square law
  logic [QW-1:0]     ratio;
  paf_pkg::dv_side_t dv_line_q [QW];

  paf_div u_ratio_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({4'd0, b1_side_q.inner, 30'd0}),
    .den_i (b1_side_q.r),
    .quo_o (ratio)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_line_q[0] <= b1_side_q;
      for (int i = 1; i < QW; i++) begin
        dv_line_q[i] <= dv_line_q[i-1];
      end
    end
  end

  // coefficient: ratio squared
  logic [59:0]       qq;
  logic [29:0]       c1_q2_q;
  paf_pkg::dv_side_t c1_side_q;

  assign qq = {30'd0, ratio[29:0]} * {30'd0, ratio[29:0]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q2_q   <= qq[59:30];
      c1_side_q <= dv_line_q[QW-1];
    end
  end

  // coefficient: partial products of mass-gain by the law factor
  logic [31:0]       sel;
  logic [63:0]       c2_lo_q;
  logic [63:0]       c2_hi_q;
  paf_pkg::dv_side_t c2_side_q;

  assign sel = (law_q == paf_pkg::LAW_SQUARE) ? {2'd0, c1_q2_q} : c1_side_q.dm;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_lo_q   <= {32'd0, c1_side_q.m[31:0]} * {32'd0, sel};
      c2_hi_q   <= {32'd0, c1_side_q.m[63:32]} * {32'd0, sel};
      c2_side_q <= c1_side_q;
    end
  end

  // coefficient: full product
  logic [95:0]       c3_full_q;
  paf_pkg::dv_side_t c3_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c3_full_q <= {32'd0, c2_lo_q} + {c2_hi_q, 32'd0};
      c3_side_q <= c2_side_q;
    end
  end

  // coefficient: scale, saturate and sign
  logic [95:0]      shifted;
  logic [32:0]      cm;
  logic             cneg;
  paf_pkg::fc_side_t c4_side_q;

  assign shifted = (law_q == paf_pkg::LAW_SQUARE) ? (c3_full_q >> 46) : (c3_full_q >> 32);
  assign cm      = (shifted > {63'd0, paf_pkg::CM_CAP}) ? paf_pkg::CM_CAP : shifted[32:0];
  assign cneg    = ((law_q == paf_pkg::LAW_SQUARE) || c3_side_q.cneg_lin) && (cm != '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_side_q.sm   <= c3_side_q.sm;
      c4_side_q.sn   <= c3_side_q.sn;
      c4_side_q.r    <= c3_side_q.r;
      c4_side_q.cm   <= cm;
      c4_side_q.cneg <= cneg;
      c4_side_q.band <= c3_side_q.band;
    end
  end

  // coefficient times separation, low partial products
  logic [2:0][63:0]  c5_pl_q;
  paf_pkg::fc_side_t c5_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c5_pl_q[k] <= {32'd0, c4_side_q.cm[31:0]} * {32'd0, c4_side_q.sm[k]};
      end
      c5_side_q <= c4_side_q;
    end
  end

  // coefficient times separation, top bit folded in
  logic [2:0][64:0]  c6_num_q;
  paf_pkg::fc_side_t c6_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c6_num_q[k] <= {1'b0, c5_pl_q[k]} +
                       (c5_side_q.cm[32] ? {1'b0, c5_side_q.sm[k], 32'd0} : 65'd0);
      end
      c6_side_q <= c5_side_q;
    end
  end

  // force components: divide by distance
  logic [2:0][QW-1:0] fq;
  paf_pkg::fc_side_t  fc_line_q [QW];

  for (genvar k = 0; k < 3; k++) begin : g_fdiv
    paf_div u_force_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (c6_num_q[k]),
      .den_i (c6_side_q.r),
      .quo_o (fq[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fc_line_q[0] <= c6_side_q;
      for (int i = 1; i < QW; i++) begin
        fc_line_q[i] <= fc_line_q[i-1];
      end
    end
  end

  // force saturation and encoding
  paf_pkg::fc_side_t fc_out;
  logic [2:0]        fneg;
  logic [2:0][31:0]  d1_fm_q;
  logic [2:0]        d1_fn_q;
  logic [2:0][31:0]  d1_force_q;
  logic [2:0][31:0]  d1_sm_q;
  logic [2:0]        d1_sn_q;
  logic              d1_band_q;

  assign fc_out = fc_line_q[QW-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fneg[k] = (fc_out.cneg != fc_out.sn[k]) && (fq[k] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1_fm_q[k]    <= paf_pkg::sat_mag({15'd0, fq[k]}, fneg[k]);
        d1_force_q[k] <= paf_pkg::enc_sat({15'd0, fq[k]}, fneg[k]);
      end
      d1_fn_q   <= fneg;
      d1_sm_q   <= fc_out.sm;
      d1_sn_q   <= fc_out.sn;
      d1_band_q <= fc_out.band;
    end
  end

  // virial products: xx yy zz xy xz yz
  logic [5:0][63:0] d2_vp_q;
  logic [5:0]       d2_vs_q;
  logic [2:0][31:0] d2_force_q;
  logic             d2_band_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_vp_q[0] <= {32'd0, d1_sm_q[0]} * {32'd0, d1_fm_q[0]};
      d2_vp_q[1] <= {32'd0, d1_sm_q[1]} * {32'd0, d1_fm_q[1]};
      d2_vp_q[2] <= {32'd0, d1_sm_q[2]} * {32'd0, d1_fm_q[2]};
      d2_vp_q[3] <= {32'd0, d1_sm_q[0]} * {32'd0, d1_fm_q[1]};
      d2_vp_q[4] <= {32'd0, d1_sm_q[0]} * {32'd0, d1_fm_q[2]};
      d2_vp_q[5] <= {32'd0, d1_sm_q[1]} * {32'd0, d1_fm_q[2]};
      d2_vs_q    <= {d1_sn_q[1] ^ d1_fn_q[2], d1_sn_q[0] ^ d1_fn_q[2],
                     d1_sn_q[0] ^ d1_fn_q[1], d1_sn_q[2] ^ d1_fn_q[2],
                     d1_sn_q[1] ^ d1_fn_q[1], d1_sn_q[0] ^ d1_fn_q[0]};
      d2_force_q <= d1_force_q;
      d2_band_q  <= d1_band_q;
    end
  end

  // output register, zero when out of band
  paf_pkg::pair_out_t out_d;
  paf_pkg::pair_out_t out_q;
  logic [5:0][31:0]   vir;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      vir[j] = paf_pkg::enc_sat(d2_vp_q[j][63:16], d2_vs_q[j]);
    end
    out_d = '0;
    if (d2_band_q) begin
      out_d.force_x = d2_force_q[0];
      out_d.force_y = d2_force_q[1];
      out_d.force_z = d2_force_q[2];
      out_d.vir_xx  = vir[0];
      out_d.vir_yy  = vir[1];
      out_d.vir_zz  = vir[2];
      out_d.vir_xy  = vir[3];
      out_d.vir_xz  = vir[4];
      out_d.vir_yz  = vir[5];
      out_d.in_band = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[PD-1];
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/paf_check.sv
// port-level checks for the pair adhesion force pipeline
module paf_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input paf_pkg::pair_out_t out_data_o
);

  // a result not taken holds with its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // out of band results carry no force and no virial
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_band |->
      out_data_o.force_x == 0 && out_data_o.force_y == 0 && out_data_o.force_z == 0 &&
      out_data_o.vir_xx == 0 && out_data_o.vir_yy == 0 && out_data_o.vir_zz == 0 &&
      out_data_o.vir_xy == 0 && out_data_o.vir_xz == 0 && out_data_o.vir_yz == 0)
    else $error("force outside band");

  // a stalled output holds the input side too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind pair_adhesion_force paf_check u_paf_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: verif/pair_adhesion_force_tb.sv
// self-checking testbench of the pair adhesion force pipeline
module pair_adhesion_force_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 111;
  localparam int CYCLE_CAP = 400000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  paf_pkg::pair_in_t in_data;
  paf_pkg::pair_out_t out_data;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [31:0] cfg_data;

  paf_pkg::pair_in_t pending_pairs[$];
  paf_pkg::pair_out_t expected_forces[$];
  logic [31:0] model_gain;
  logic model_law;
  int errors, results_seen, in_band_seen, cycles;
  int hold_off;      // long receiver stall, counted in its own process
  bit in_hold;
  bit hold_done;
  bit sender_pause;
  int gap;

  pair_adhesion_force u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b / 2^sh), capped at the coefficient limit
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    p = p >> sh;
    return (p > 128'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] to_signed_sat(logic [63:0] m, logic neg);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(64'h1_0000_0000 - m);
    end
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  // adhesion force and virials for one pair
  function automatic paf_pkg::pair_out_t adhesion_force(paf_pkg::pair_in_t p);
    paf_pkg::pair_out_t o;
    logic [63:0] sm[3], fm[3];
    logic sn[3], fn[3];
    logic [31:0] sv[3];
    logic [63:0] inner, outer, ma, mb, m, rsq, r, cm, midr, dm, q, q2, f;
    logic cneg;
    sv[0] = p.sep_x; sv[1] = p.sep_y; sv[2] = p.sep_z;
    for (int k = 0; k < 3; k++) begin
      sn[k] = sv[k][31];
      sm[k] = sn[k] ? 64'h1_0000_0000 - {32'd0, sv[k]} : {32'd0, sv[k]};
    end
    inner = {33'd0, p.inner_radius_sum};
    outer = {33'd0, p.outer_radius_sum};
    ma = {33'd0, (p.adhesive_a ? p.own_mass_a : p.shell_mass_a)};
    mb = {33'd0, (p.adhesive_b ? p.own_mass_b : p.shell_mass_b)};
    m = (ma + mb) * {32'd0, model_gain};
    rsq = sm[0]*sm[0] + sm[1]*sm[1] + sm[2]*sm[2];
    r = int_root(rsq);
    o = '0;
    if (!(r > inner && r < outer)) return o;
    if (model_law == paf_pkg::LAW_LINEAR) begin
      midr = (inner + outer) >> 1;
      if (r >= midr) begin
        dm = r - midr;
        cneg = dm != 0;
      end else begin
        dm = midr - r;
        cneg = 1'b0;
      end
      cm = scaled_product(m, dm, 32);
    end else begin
      q = (inner << 30) / r;
      q2 = (q * q) >> 30;
      cm = scaled_product(m, q2, 46);
      cneg = 1'b1;
    end
    if (cm == 0) cneg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      f = (cm * sm[k]) / r;
      fn[k] = (cneg != sn[k]) && f != 0;
      if (fn[k] && f > 64'h8000_0000) f = 64'h8000_0000;
      if (!fn[k] && f > 64'h7FFF_FFFF) f = 64'h7FFF_FFFF;
      fm[k] = f;
    end
    o.force_x = to_signed_sat(fm[0], fn[0]);
    o.force_y = to_signed_sat(fm[1], fn[1]);
    o.force_z = to_signed_sat(fm[2], fn[2]);
    o.vir_xx = to_signed_sat((sm[0]*fm[0]) >> 16, sn[0] != fn[0]);
    o.vir_yy = to_signed_sat((sm[1]*fm[1]) >> 16, sn[1] != fn[1]);
    o.vir_zz = to_signed_sat((sm[2]*fm[2]) >> 16, sn[2] != fn[2]);
    o.vir_xy = to_signed_sat((sm[0]*fm[1]) >> 16, sn[0] != fn[1]);
    o.vir_xz = to_signed_sat((sm[0]*fm[2]) >> 16, sn[0] != fn[2]);
    o.vir_yz = to_signed_sat((sm[1]*fm[2]) >> 16, sn[1] != fn[2]);
    o.in_band = 1'b1;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sender: one transfer per handshake, random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_forces.push_back(adhesion_force(in_data));
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0 && !sender_pause) begin
          in_data <= pending_pairs.pop_front();
          in_valid <= 1'b1;
          gap <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 40)) :
                                                 int'($urandom_range(1, 3))) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_off <= 0;
      hold_done <= 1'b0;
    end else if (in_hold && !hold_done) begin
      hold_off <= 300;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // receiver: random stalls plus one long hold-off, checks each transfer
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          report_mismatch("unexpected result", out_data.force_x, '0);
        end else begin
          paf_pkg::pair_out_t w;
          w = expected_forces.pop_front();
          results_seen++;
          if (w.in_band) in_band_seen++;
          if (out_data.force_x !== w.force_x) report_mismatch("force_x", out_data.force_x, w.force_x);
          if (out_data.force_y !== w.force_y) report_mismatch("force_y", out_data.force_y, w.force_y);
          if (out_data.force_z !== w.force_z) report_mismatch("force_z", out_data.force_z, w.force_z);
          if (out_data.vir_xx !== w.vir_xx) report_mismatch("vir_xx", out_data.vir_xx, w.vir_xx);
          if (out_data.vir_yy !== w.vir_yy) report_mismatch("vir_yy", out_data.vir_yy, w.vir_yy);
          if (out_data.vir_zz !== w.vir_zz) report_mismatch("vir_zz", out_data.vir_zz, w.vir_zz);
          if (out_data.vir_xy !== w.vir_xy) report_mismatch("vir_xy", out_data.vir_xy, w.vir_xy);
          if (out_data.vir_xz !== w.vir_xz) report_mismatch("vir_xz", out_data.vir_xz, w.vir_xz);
          if (out_data.vir_yz !== w.vir_yz) report_mismatch("vir_yz", out_data.vir_yz, w.vir_yz);
          if (out_data.in_band !== w.in_band)
            report_mismatch("in_band", 32'(out_data.in_band), 32'(w.in_band));
        end
      end
      if (hold_off > 0 || (in_hold && !hold_done)) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 4) != 0) ||
                     ($urandom_range(0, 7) == 0 && $urandom_range(0, 1) == 0);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // random pair, biased towards in band separations
  function automatic paf_pkg::pair_in_t random_pair(int flavour);
    paf_pkg::pair_in_t p;
    int unsigned sc;
    p.own_mass_a = 31'($urandom); p.shell_mass_a = 31'($urandom);
    p.own_mass_b = 31'($urandom); p.shell_mass_b = 31'($urandom);
    p.adhesive_a = 1'($urandom_range(0, 1)); p.adhesive_b = 1'($urandom_range(0, 1));
    if (flavour == 0) begin
      p.sep_x = $urandom; p.sep_y = $urandom; p.sep_z = $urandom;
      p.inner_radius_sum = 31'($urandom); p.outer_radius_sum = 31'($urandom);
    end else begin
      sc = $urandom_range(4, 26);
      p.sep_x = $signed(32'($urandom_range(0, (1 << sc)))) * ($urandom_range(0, 1) ? 1 : -1);
      p.sep_y = $signed(32'($urandom_range(0, (1 << sc)))) * ($urandom_range(0, 1) ? 1 : -1);
      p.sep_z = $signed(32'($urandom_range(0, (1 << sc)))) * ($urandom_range(0, 1) ? 1 : -1);
      p.inner_radius_sum = 31'($urandom_range(0, (1 << sc) / 2));
      p.outer_radius_sum = 31'($urandom_range((1 << sc), (1 << sc) * 2));
      if ($urandom_range(0, 2) == 0) begin
        p.own_mass_a = 31'($urandom_range(0, 1 << 20));
        p.shell_mass_a = 31'($urandom_range(0, 1 << 20));
        p.own_mass_b = 31'($urandom_range(0, 1 << 20));
        p.shell_mass_b = 31'($urandom_range(0, 1 << 20));
      end
    end
    return p;
  endfunction

  function automatic paf_pkg::pair_in_t directed_pair(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z,
                                                      logic [30:0] ri, logic [30:0] ro,
                                                      logic [30:0] mass, logic [1:0] adh);
    paf_pkg::pair_in_t p;
    p.sep_x = x; p.sep_y = y; p.sep_z = z;
    p.inner_radius_sum = ri; p.outer_radius_sum = ro;
    p.own_mass_a = mass; p.shell_mass_a = ~mass;
    p.own_mass_b = ~mass; p.shell_mass_b = mass;
    p.adhesive_a = adh[1]; p.adhesive_b = adh[0];
    return p;
  endfunction

  // send everything queued, then hold the sender until all results are back
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid) @(posedge clk);
    sender_pause = 1;
    while (expected_forces.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    sender_pause = 0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == paf_pkg::REG_GAIN) model_gain = val; else model_law = val[0];
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      pending_pairs.push_back(random_pair(int'($urandom_range(0, 4) != 0)));
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    model_gain = '0; model_law = paf_pkg::LAW_LINEAR;
    errors = 0; results_seen = 0; in_band_seen = 0; cycles = 0;
    in_hold = 0; sender_pause = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset gain: everything zero even in band
    pending_pairs.push_back(directed_pair(32'h0002_0000, 0, 0, 31'h1_0000, 31'h4_0000,
                                          31'h1_0000, 2'b11));
    drain();

    write_reg(paf_pkg::REG_GAIN, 32'h0001_0000);
    write_reg(paf_pkg::REG_LAW, {31'd0, paf_pkg::LAW_LINEAR});
    // zero distance, on inner and outer boundaries, below and at the midpoint
    pending_pairs.push_back(directed_pair(0, 0, 0, 0, 31'h4_0000, 31'h1_0000, 2'b00));
    pending_pairs.push_back(directed_pair(32'h0001_0000, 0, 0, 31'h1_0000, 31'h4_0000,
                                          31'h1_0000, 2'b01));
    pending_pairs.push_back(directed_pair(0, 32'hFFFC_0000, 0, 31'h1_0000, 31'h4_0000,
                                          31'h1_0000, 2'b10));
    pending_pairs.push_back(directed_pair(0, 0, 32'hFFFE_0000, 31'h1_0000, 31'h4_0000,
                                          31'h1_0000, 2'b11));
    pending_pairs.push_back(directed_pair(32'h0002_8000, 0, 0, 31'h1_0000, 31'h4_0000,
                                          31'h1_0000, 2'b00));
    pending_pairs.push_back(directed_pair(32'hFFFE_8000, 32'h0001_0000, 32'hFFFF_0000,
                                          31'h1_0000, 31'h4_0000, 31'h2_0000, 2'b01));
    pending_pairs.push_back(directed_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 2'b11));
    pending_pairs.push_back(directed_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 2'b00));
    drain();

    // maximum gain in both laws: saturation of the coefficient and forces
    write_reg(paf_pkg::REG_GAIN, 32'hFFFF_FFFF);
    pending_pairs.push_back(directed_pair(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0001, 0,
                                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 2'b11));
    pending_pairs.push_back(directed_pair(32'h7FFF_0000, 0, 0, 0, 31'h7FFF_FFFF,
                                          31'h7FFF_FFFF, 2'b00));
    drain();
    write_reg(paf_pkg::REG_LAW, {31'd0, paf_pkg::LAW_SQUARE});
    pending_pairs.push_back(directed_pair(32'h0002_0000, 0, 0, 31'h1_0000, 31'h4_0000,
                                          31'h7FFF_FFFF, 2'b10));
    pending_pairs.push_back(directed_pair(32'h0001_0001, 0, 0, 31'h1_0000, 31'h4_0000,
                                          31'h7FFF_FFFF, 2'b01));
    pending_pairs.push_back(directed_pair(0, 0, 32'hFFFF_FFF0, 0, 31'h4_0000,
                                          31'h1_0000, 2'b11));
    drain();

    // random phases over several settings; long receiver stall in the first
    write_reg(paf_pkg::REG_GAIN, 32'h0000_4000);
    in_hold = 1;
    random_phase(120);
    drain();
    write_reg(paf_pkg::REG_LAW, {31'd0, paf_pkg::LAW_LINEAR});
    write_reg(paf_pkg::REG_GAIN, $urandom);
    random_phase(110);
    drain();
    write_reg(paf_pkg::REG_GAIN, 32'h0000_0001);
    random_phase(100);
    drain();
    write_reg(paf_pkg::REG_LAW, {31'd0, paf_pkg::LAW_SQUARE});
    write_reg(paf_pkg::REG_GAIN, $urandom);
    random_phase(110);
    drain();

    $display("checked %0d results, %0d in band, both laws, gain from zero to full scale",
             results_seen, in_band_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/paf_pkg.sv
hw/rtl/paf_sqrt.sv
hw/rtl/paf_div.sv
hw/rtl/pair_adhesion_force.sv
hw/rtl/paf_check.sv
verif/pair_adhesion_force_tb.sv
